>>> rtl/sha_pkg.sv
package sha_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned Rounds = 64;
  localparam int unsigned RoundW = 6;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take_byte;
    logic       start_blk;
    logic       round;
    logic       add_cv;
    logic       pad_first;
    logic       pad_len_only;
    logic       pad_len;
    logic       finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       blk_full;
    logic       last_round;
    logic       two_pad;
  } sts_t;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

endpackage

>>> rtl/sha_ctrl.sv
module sha_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          in_has_byte,
  input  logic          in_last,
  input  logic          out_fire,
  input  sha_pkg::sts_t sts,
  output sha_pkg::cmd_t cmd,
  output logic          in_tready,
  output logic          out_tvalid
);
  import sha_pkg::*;

  state_t state_r, state_nxt;
  // Set while the current compression is the final one of the message.
  logic   final_r, final_nxt;
  // Set while a second padding block (length only) is still owed.
  logic   more_r, more_nxt;
  // End of message seen on the beat that started the running block.
  logic   endq_r, endq_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      final_r <= 1'b0;
      more_r  <= 1'b0;
      endq_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      final_r <= final_nxt;
      more_r  <= more_nxt;
      endq_r  <= endq_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    final_nxt  = final_r;
    more_nxt   = more_r;
    endq_nxt   = endq_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          cmd.take_byte = in_has_byte;
          if (in_has_byte && sts.blk_full) begin
            cmd.start_blk = 1'b1;
            endq_nxt      = in_last;
            final_nxt     = 1'b0;
            state_nxt     = ST_ROUND;
          end else if (in_last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (sts.last_round) state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add_cv = 1'b1;
        if (final_r) begin
          state_nxt = ST_OUT;
        end else if (more_r) begin
          more_nxt      = 1'b0;
          final_nxt     = 1'b1;
          cmd.pad_len_only = 1'b1;
          state_nxt     = ST_PAD;
        end else if (endq_r) begin
          endq_nxt  = 1'b0;
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PAD: begin
        // Build the padding block (first pass, or the length words of the second) and start compressing it.
        cmd.start_blk = 1'b1;
        if (final_r) begin
          cmd.pad_len = 1'b1;
        end else begin
          cmd.pad_first = 1'b1;
          if (sts.two_pad) begin
            more_nxt = 1'b1;
          end else begin
            cmd.pad_len = 1'b1;
            final_nxt   = 1'b1;
          end
        end
        state_nxt = ST_ROUND;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_fire) begin
          cmd.finish = 1'b1;
          final_nxt  = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_out_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> final_r) else $error("digest shown before final block");
  a_pad_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(final_r && more_r)) else $error("second pad owed on final block");
`endif

endmodule

>>> rtl/sha_dp.sv
module sha_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     in_byte,
  input  sha_pkg::cmd_t  cmd,
  output sha_pkg::sts_t  sts,
  output sha_pkg::word_t dig [8]
);
  import sha_pkg::*;

  // Block buffer held as sixteen big-endian words.
  word_t       buf_r [16];
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  word_t       cv_r [8];
  word_t       wv_r [8];
  word_t       w_r  [16];
  logic [RoundW-1:0] rnd_r;

  word_t w15, w2, wt, s0, s1, ch, mj, t1, t2, ls0, ls1, wnew;
  logic  is_sched;

  assign is_sched = (rnd_r >= RoundW'(16));
  assign w15 = w_r[1];
  assign w2  = w_r[14];
  assign ls0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
  assign ls1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
  assign wnew = ls1 + w_r[9] + ls0 + w_r[0];
  assign wt  = is_sched ? wnew : w_r[0];

  assign s1 = rotr(wv_r[4], 6) ^ rotr(wv_r[4], 11) ^ rotr(wv_r[4], 25);
  assign ch = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
  assign t1 = wv_r[7] + s1 + ch + RoundK[rnd_r] + wt;
  assign s0 = rotr(wv_r[0], 2) ^ rotr(wv_r[0], 13) ^ rotr(wv_r[0], 22);
  assign mj = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
  assign t2 = s0 + mj;

  assign sts.blk_full   = (fill_r == 6'd63);
  assign sts.last_round = (rnd_r == RoundW'(Rounds - 1));
  assign sts.two_pad    = (fill_r >= 6'd56);

  always_comb begin
    for (int k = 0; k < 8; k++) dig[k] = cv_r[k];
  end

  // Control counters and chaining value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      bits_r <= '0;
      rnd_r  <= '0;
      for (int k = 0; k < 8; k++) cv_r[k] <= InitHash[k];
    end else begin
      if (cmd.take_byte) begin
        fill_r <= fill_r + 6'd1;
        bits_r <= bits_r + 64'd8;
      end
      if (cmd.start_blk) rnd_r <= '0;
      else if (cmd.round) rnd_r <= rnd_r + RoundW'(1);
      if (cmd.add_cv) begin
        for (int k = 0; k < 8; k++) cv_r[k] <= cv_r[k] + wv_r[k];
      end
      if (cmd.finish) begin
        fill_r <= '0;
        bits_r <= '0;
        for (int k = 0; k < 8; k++) cv_r[k] <= InitHash[k];
      end
    end
  end

  // Buffer, schedule window and working variables.
  always_ff @(posedge clk) begin
    word_t nb [16];
    for (int k = 0; k < 16; k++) nb[k] = buf_r[k];
    if (cmd.take_byte) nb[fill_r[5:2]][8*(3-fill_r[1:0]) +: 8] = in_byte;
    if (cmd.pad_first) begin
      for (int k = 0; k < 64; k++) begin
        if (k == fill_r) nb[k/4][8*(3-k%4) +: 8] = 8'h80;
        else if (k > fill_r) nb[k/4][8*(3-k%4) +: 8] = 8'h00;
      end
    end
    if (cmd.pad_len_only) begin
      for (int k = 0; k < 16; k++) nb[k] = '0;
    end
    if (cmd.pad_len) begin
      nb[14] = bits_r[63:32];
      nb[15] = bits_r[31:0];
    end
    for (int k = 0; k < 16; k++) buf_r[k] <= nb[k];
    if (cmd.start_blk) begin
      for (int k = 0; k < 16; k++) w_r[k] <= nb[k];
      for (int k = 0; k < 8; k++) wv_r[k] <= cv_r[k];
    end else if (cmd.round) begin
      for (int k = 0; k < 15; k++) w_r[k] <= w_r[k+1];
      w_r[15] <= wt;
      wv_r[7] <= wv_r[6];
      wv_r[6] <= wv_r[5];
      wv_r[5] <= wv_r[4];
      wv_r[4] <= wv_r[3] + t1;
      wv_r[3] <= wv_r[2];
      wv_r[2] <= wv_r[1];
      wv_r[1] <= wv_r[0];
      wv_r[0] <= t1 + t2;
    end
  end

`ifndef SYNTHESIS
  a_round_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round && sts.last_round |=> rnd_r == '0) else $error("round count off");
  a_bits_align: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r[2:0] == 3'b000) else $error("bit count not byte aligned");
  a_finish_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> fill_r == '0 && bits_r == '0) else $error("finish left state");
`endif

endmodule

>>> rtl/sha256_message_hasher_core.sv
// SHA-256 hasher over a byte stream.
// Input channel: one beat carries a byte (in_tdata), a byte flag (in_tuser)
// and an end-of-message mark (in_tlast). A beat with in_tuser low and
// in_tlast high ends a message without adding a byte; with both low it
// does nothing.
// Output channel: one beat per message, the 256-bit digest with H0 in the
// lowest 32 bits of out_tdata, H7 in the highest.
// A byte that does not complete a 64-byte block leaves the input ready.
// A byte that completes a block holds the input while it is compressed:
// 64 rounds on the single shared round unit, one chaining add, then idle.
// End of message adds one or two padding blocks before the digest is
// shown; the input stays stalled until the digest beat is taken, so a
// stalled receiver holds the whole block.
// Reset: synchronous, active low; clears the length, the fill count and
// loads the initial hash words. The buffer contents need no clearing.
module sha256_message_hasher_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tuser,   // has_byte
  input  logic         in_tlast,   // last
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [255:0] out_tdata   // digest_word_0 .. digest_word_7
);
  import sha_pkg::*;

  cmd_t  cmd;
  sts_t  sts;
  word_t dig [8];
  logic  in_fire, out_fire;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  // Controller.
  sha_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_has_byte(in_tuser), .in_last(in_tlast),
    .out_fire, .sts, .cmd, .in_tready, .out_tvalid
  );

  // Datapath.
  sha_dp u_dp (
    .clk, .rst_n, .in_byte(in_tdata), .cmd, .sts, .dig
  );

  // Digest packing, H0 lowest.
  always_comb begin
    for (int k = 0; k < 8; k++) out_tdata[32*k +: 32] = dig[k];
  end

endmodule

>>> verif/tb_sha256_message_hasher_core.sv
`timescale 1ns / 1ps

module tb_sha256_message_hasher_core;

  import sha_pkg::*;

  // One input beat as packed into the stream fields.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } msg_beat_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [255:0] out_tdata;

  msg_beat_t    pending_beats[$];
  logic [255:0] expected_digests[$];

  // Hashing state of the predictor.
  word_t        hash_state[8];
  logic [7:0]   blk_bytes[64];
  int unsigned  blk_fill;
  logic [63:0]  bit_len;

  int unsigned  mismatch_cnt = 0;
  bit           stim_done = 1'b0;
  bit           calm = 1'b0;
  int unsigned  in_gap = 0;
  int unsigned  out_gap = 0;

  sha256_message_hasher_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // data_byte
    .in_tuser   (in_tuser),    // has_byte
    .in_tlast   (in_tlast),    // last
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)    // digest_word_0 .. digest_word_7
  );

  always #5 clk = ~clk;

  function automatic word_t ror32(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Standard 64-round compression of the current block into the hash state.
  function automatic void compress_blk();
    word_t w[64];
    word_t v[8];
    word_t t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
             (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    v = hash_state;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int k = 0; k < 8; k++) hash_state[k] += v[k];
  endfunction

  function automatic void restart_msg();
    hash_state = InitHash;
    blk_fill = 0;
    bit_len = '0;
  endfunction

  // Advance the predictor by one accepted beat; queue a digest on end of message.
  function automatic void hash_beat(msg_beat_t b);
    logic [255:0] dig;
    if (b.has_byte) begin
      blk_bytes[blk_fill] = b.data_byte;
      bit_len += 64'd8;
      blk_fill++;
      if (blk_fill == 64) begin
        compress_blk();
        blk_fill = 0;
      end
    end
    if (b.last) begin
      blk_bytes[blk_fill] = 8'h80;
      for (int i = blk_fill + 1; i < 64; i++) blk_bytes[i] = '0;
      if (blk_fill >= 56) begin
        compress_blk();
        for (int i = 0; i < 64; i++) blk_bytes[i] = '0;
      end
      for (int i = 0; i < 8; i++) blk_bytes[63-i] = bit_len[8*i +: 8];
      compress_blk();
      for (int k = 0; k < 8; k++) dig[32*k +: 32] = hash_state[k];
      expected_digests.push_back(dig);
      restart_msg();
    end
  endfunction

  // Queue one message of the given length; idle beats sprinkled in for pattern 2.
  task automatic add_msg(int unsigned len, bit end_with_byte, int unsigned pattern);
    msg_beat_t b;
    for (int i = 0; i < len; i++) begin
      if (pattern == 2 && $urandom_range(0, 15) == 0)
        pending_beats.push_back('{data_byte: 8'($urandom), has_byte: 1'b0, last: 1'b0});
      b.data_byte = (pattern == 0) ? 8'hff : (pattern == 1) ? 8'h00 : 8'($urandom);
      b.has_byte = 1'b1;
      b.last = end_with_byte && (i == len - 1);
      pending_beats.push_back(b);
    end
    if (!end_with_byte || len == 0)
      pending_beats.push_back('{data_byte: 8'($urandom), has_byte: 1'b0, last: 1'b1});
  endtask

  // Stimulus: short directed messages, then random messages, then directed lengths at the block boundaries.
  initial begin
    int unsigned total;
    int unsigned len;
    restart_msg();
    add_msg(0, 1'b0, 2);
    add_msg(1, 1'b1, 0);
    add_msg(1, 1'b1, 1);
    pending_beats.push_back('{data_byte: 8'h00, has_byte: 1'b0, last: 1'b0});
    pending_beats.push_back('{data_byte: 8'hff, has_byte: 1'b0, last: 1'b0});
    add_msg(3, 1'b0, 2);
    add_msg(0, 1'b0, 2);
    total = 0;
    foreach (pending_beats[i]) total++;
    // Idle beats and the closing messages bring the run to about 1700 beats.
    while (total < 1420) begin
      case ($urandom_range(0, 5))
        0: len = $urandom_range(54, 66);
        1: len = 64 * $urandom_range(1, 2);
        2: len = $urandom_range(118, 130);
        default: len = $urandom_range(0, 40);
      endcase
      add_msg(len, 1'($urandom), 2);
      total += len + 1;
    end
    // Long directed messages at block edges at the end.
    add_msg(55, 1'b1, 2);
    add_msg(56, 1'b0, 2);
    add_msg(64, 1'b1, 2);
  end

  // Reset once at the start.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: presents queued beats, with random gaps until the queue runs low.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        hash_beat(pending_beats.pop_front());
        if (pending_beats.size() < 200) calm = 1'b1;
      end
      if (in_tvalid && !in_tready) begin
        // Hold the beat until it is taken.
      end else if (pending_beats.size() == 0) begin
        in_tvalid <= 1'b0;
        stim_done = 1'b1;
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 7);
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_beats[0].data_byte;
        in_tuser <= pending_beats[0].has_byte;
        in_tlast <= pending_beats[0].last;
      end
    end
  end

  // Monitor: compares each digest beat and, until the input queue runs low, stalls the receiver at random.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_digests.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("Unexpected digest %h", out_tdata);
        end else begin
          logic [255:0] want;
          want = expected_digests.pop_front();
          for (int k = 0; k < 8; k++)
            if (want[32*k +: 32] !== out_tdata[32*k +: 32]) begin
              mismatch_cnt++;
              if (mismatch_cnt <= 10)
                $display("Digest word %0d: expected %h, got %h", k,
                         want[32*k +: 32], out_tdata[32*k +: 32]);
            end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 7);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // End of run: all beats sent, all digests seen, then drain.
  initial begin
    wait (rst_n && stim_done && expected_digests.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatch_cnt == 0 && expected_digests.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/sha_pkg.sv
rtl/sha_ctrl.sv
rtl/sha_dp.sv
rtl/sha256_message_hasher_core.sv
verif/tb_sha256_message_hasher_core.sv
